// File: rtl/core/buck_pi_voltage_controller_unit_defines.svh
// Assertion macros for the buck PI voltage controller.
`ifndef BUCK_PI_VOLTAGE_CONTROLLER_UNIT_DEFINES_SVH
`define BUCK_PI_VOLTAGE_CONTROLLER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BPVC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("bpvc: check failed");
`define BPVC_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
	else $error("bpvc: check failed");
`else
`define BPVC_ASSERT(lbl, prop)
`define BPVC_ASSERT_NEXT(lbl, cond, prop)
`endif
`endif

// File: rtl/core/bpvc_pkg.sv
`timescale 1ns / 1ps
package bpvc_pkg;
	localparam int ADC_W       = 10;
	localparam int OUT_SHIFT   = 5;
	localparam int PI_LIMIT    = 55200;
	localparam int FB_BIAS     = 2;
	localparam int PI_W        = 17;
	localparam int REF_W       = 17;
	localparam int ERR_W       = REF_W + 1;
	localparam int DUTY_W      = 12;
	localparam int GAIN_W      = 10;
	localparam int TGT_W       = 11;
	localparam int PID_W       = 7;
	localparam int SOFT_W      = 16;
	localparam int Q_DEPTH     = 4;
	localparam int Q_AW        = $clog2(Q_DEPTH);
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 17;
	localparam int IN_TDATA_W  = ((2 * ADC_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((DUTY_W + 1 + REF_W + 7) / 8) * 8;

	localparam logic [GAIN_W-1:0]       RST_P_GAIN    = GAIN_W'(32);
	localparam logic [GAIN_W-1:0]       RST_I_GAIN    = GAIN_W'(1);
	localparam logic [TGT_W-1:0]        RST_TARGET    = TGT_W'(1000);
	localparam logic signed [REF_W-1:0] RST_START_REF = -REF_W'(1725);
	localparam logic [PID_W-1:0]        RST_PID_PER   = PID_W'(10);
	localparam logic [SOFT_W-1:0]       RST_SOFT_PER  = SOFT_W'(1000);
	localparam logic [ADC_W-1:0]        RST_CUR_LIMIT = ADC_W'(1023);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_P_GAIN    = 3'd0,
		REG_I_GAIN    = 3'd1,
		REG_TARGET    = 3'd2,
		REG_START_REF = 3'd3,
		REG_PID_PER   = 3'd4,
		REG_SOFT_PER  = 3'd5,
		REG_CUR_LIMIT = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_CURR  = 2'd1,
		CMD_START = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_CURR  = 2'd1,
		OP_START = 2'd2,
		OP_HOLD  = 2'd3
	} op_t;

	typedef struct packed {
		logic [GAIN_W-1:0]       p_gain;
		logic [GAIN_W-1:0]       i_gain;
		logic [TGT_W-1:0]        target_ref;
		logic signed [REF_W-1:0] start_ref;
		logic [PID_W-1:0]        pid_period;
		logic [SOFT_W-1:0]       soft_period;
		logic [ADC_W-1:0]        cur_limit;
	} cfg_t;

	typedef struct packed {
		op_t              op;
		logic             pi_fire;
		logic             ramp_fire;
		logic             trip;
		logic [ADC_W-1:0] vs;
	} fe_item_t;
endpackage

// File: rtl/core/bpvc_front.sv
`timescale 1ns / 1ps
module bpvc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bpvc_pkg::cfg_t                 cfg,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [9:0] voltage_sample, [19:10] current_sample, rest zero
	input  logic [bpvc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	// [1:0] cmd
	input  logic [1:0]                     s_axis_tuser,
	input  logic                           q_full,
	output logic                           push,
	output bpvc_pkg::fe_item_t             push_item
);
	import bpvc_pkg::*;

	logic [PID_W-1:0]  sample_cnt_q;
	logic [SOFT_W-1:0] ramp_cnt_q;
	logic [PID_W-1:0]  sc_inc;
	logic [SOFT_W-1:0] rc_inc;
	logic [ADC_W-1:0]  vs;
	logic [ADC_W-1:0]  cs;
	cmd_t              cmd;

	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && s_axis_tready;
	assign vs            = s_axis_tdata[ADC_W-1:0];
	assign cs            = s_axis_tdata[2*ADC_W-1:ADC_W];
	assign cmd           = cmd_t'(s_axis_tuser);

	always_comb begin
		sc_inc              = sample_cnt_q + PID_W'(1);
		rc_inc              = ramp_cnt_q + SOFT_W'(1);
		push_item.pi_fire   = sc_inc >= cfg.pid_period;
		push_item.ramp_fire = rc_inc >= cfg.soft_period;
		push_item.trip      = cs >= cfg.cur_limit;
		push_item.vs        = vs;
		unique case (cmd)
			CMD_TICK:  push_item.op = OP_TICK;
			CMD_CURR:  push_item.op = OP_CURR;
			CMD_START: push_item.op = OP_START;
			default:   push_item.op = OP_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_cnt_q <= '0;
			ramp_cnt_q   <= '0;
		end else if (push) begin
			if (push_item.op == OP_TICK) begin
				sample_cnt_q <= push_item.pi_fire ? '0 : sc_inc;
				ramp_cnt_q   <= push_item.ramp_fire ? '0 : rc_inc;
			end else if (push_item.op == OP_START) begin
				sample_cnt_q <= '0;
				ramp_cnt_q   <= '0;
			end
		end
	end
endmodule

// File: rtl/core/bpvc_queue.sv
`timescale 1ns / 1ps
module bpvc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bpvc_pkg::fe_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               q_valid,
	output bpvc_pkg::fe_item_t head
);
	import bpvc_pkg::*;

	fe_item_t        mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_AW:0]   count_q;

	assign full    = count_q == (Q_AW+1)'(Q_DEPTH);
	assign q_valid = count_q != '0;
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + Q_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (Q_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (Q_AW+1)'(1);
			end
		end
	end
endmodule

// File: rtl/core/bpvc_back.sv
`timescale 1ns / 1ps
`include "buck_pi_voltage_controller_unit_defines.svh"
module bpvc_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bpvc_pkg::cfg_t                  cfg,
	input  logic                            q_valid,
	input  bpvc_pkg::fe_item_t              q_head,
	output logic                            q_pop,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [11:0] duty, [12] pwm_enable, [29:13] reference_now, rest zero
	output logic [bpvc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// [0] duty_updated
	output logic [0:0]                      m_axis_tuser
);
	import bpvc_pkg::*;

	localparam int PPROD_W = ERR_W + GAIN_W + 1;
	localparam int IPROD_W = PI_W + GAIN_W + 1;
	localparam logic signed [PI_W-1:0] LIM_POS = PI_W'(PI_LIMIT);
	localparam logic signed [PI_W-1:0] LIM_NEG = -PI_W'(PI_LIMIT);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_INT  = 4'b0100,
		ST_DONE = 4'b1000
	} bk_state_t;

	function automatic logic signed [PI_W-1:0] clamp_pi(input logic signed [31:0] v);
		if (v >= 32'(PI_LIMIT)) begin
			return LIM_POS;
		end
		if (v <= -32'(PI_LIMIT)) begin
			return LIM_NEG;
		end
		return PI_W'(v);
	endfunction

	bk_state_t state_q;
	bk_state_t state_d;
	fe_item_t  item_q;

	logic signed [ERR_W-1:0]   err_s1;
	logic signed [PI_W-1:0]    p_s2;
	logic signed [PI_W-1:0]    integ_s2;
	logic signed [PI_W-1:0]    i_s3;

	logic signed [PI_W-1:0]    integral_q;
	logic signed [REF_W-1:0]   vref_q;
	logic [ADC_W-1:0]          offset_q;
	logic                      pwm_q;
	logic signed [DUTY_W-1:0]  duty_q;

	logic                      m_valid_q;
	logic signed [DUTY_W-1:0]  duty_o_q;
	logic                      upd_o_q;
	logic                      pwm_o_q;
	logic signed [REF_W-1:0]   ref_o_q;

	logic signed [ADC_W+1:0]   diff;
	logic [ADC_W:0]            volt;
	logic signed [ERR_W-1:0]   err;
	logic signed [PPROD_W-1:0] p_full;
	logic signed [ERR_W:0]     isum;
	logic signed [IPROD_W-1:0] i_full;
	logic signed [PI_W:0]      pi_sum;
	logic signed [PI_W-1:0]    pi_sat;
	logic signed [DUTY_W-1:0]  duty_new;
	logic signed [REF_W:0]     ramp_inc;
	logic signed [REF_W:0]     ramp_tgt;
	logic signed [REF_W-1:0]   vref_ramp;
	logic                      commit;

	logic signed [PI_W-1:0]    integral_d;
	logic signed [REF_W-1:0]   vref_d;
	logic [ADC_W-1:0]          offset_d;
	logic                      pwm_d;
	logic signed [DUTY_W-1:0]  duty_d;
	logic                      upd_d;

	assign q_pop  = (state_q == ST_IDLE) && q_valid;
	assign commit = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

	// error against the held reference
	always_comb begin
		diff = $signed({2'b00, q_head.vs}) - $signed({2'b00, offset_q})
			- (ADC_W+2)'(FB_BIAS);
		volt = (diff < 0) ? '0 : {diff[ADC_W-1:0], 1'b0};
		err  = ERR_W'(vref_q) - $signed(ERR_W'(volt));
	end

	assign p_full = err_s1 * $signed({1'b0, cfg.p_gain});
	assign isum   = (ERR_W+1)'(integral_q) + (ERR_W+1)'(err_s1);
	assign i_full = integ_s2 * $signed({1'b0, cfg.i_gain});

	always_comb begin
		pi_sum    = (PI_W+1)'(p_s2) + (PI_W+1)'(i_s3);
		pi_sat    = clamp_pi(32'(pi_sum));
		duty_new  = DUTY_W'(pi_sat >>> OUT_SHIFT);
		ramp_inc  = (REF_W+1)'(vref_q) + (REF_W+1)'(1);
		ramp_tgt  = $signed((REF_W+1)'(cfg.target_ref));
		vref_ramp = (ramp_inc >= ramp_tgt) ? REF_W'(ramp_tgt) : REF_W'(ramp_inc);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (q_valid) state_d = ST_MUL;
			ST_MUL:  state_d = ST_INT;
			ST_INT:  state_d = ST_DONE;
			ST_DONE: if (commit) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		integral_d = integral_q;
		vref_d     = vref_q;
		offset_d   = offset_q;
		pwm_d      = pwm_q;
		duty_d     = duty_q;
		upd_d      = 1'b0;
		unique case (item_q.op)
			OP_TICK: begin
				if (item_q.pi_fire) begin
					integral_d = integ_s2;
					duty_d     = duty_new;
					upd_d      = 1'b1;
				end
				if (item_q.ramp_fire) begin
					vref_d = vref_ramp;
				end
			end
			OP_CURR: begin
				if (item_q.trip) begin
					pwm_d = 1'b0;
				end
			end
			OP_START: begin
				offset_d   = item_q.vs;
				vref_d     = cfg.start_ref;
				integral_d = '0;
				duty_d     = '0;
				pwm_d      = 1'b1;
			end
			OP_HOLD: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_head;
			err_s1 <= err;
		end
		if (state_q == ST_MUL) begin
			p_s2     <= clamp_pi(32'(p_full));
			integ_s2 <= clamp_pi(32'(isum));
		end
		if (state_q == ST_INT) begin
			i_s3 <= clamp_pi(32'(i_full));
		end
		if (commit) begin
			duty_o_q <= duty_d;
			upd_o_q  <= upd_d;
			pwm_o_q  <= pwm_d;
			ref_o_q  <= vref_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_valid_q  <= 1'b0;
			integral_q <= '0;
			vref_q     <= RST_START_REF;
			offset_q   <= '0;
			pwm_q      <= 1'b0;
			duty_q     <= '0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				m_valid_q  <= 1'b1;
				integral_q <= integral_d;
				vref_q     <= vref_d;
				offset_q   <= offset_d;
				pwm_q      <= pwm_d;
				duty_q     <= duty_d;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W-DUTY_W-1-REF_W)'(0), ref_o_q, pwm_o_q, duty_o_q};
	assign m_axis_tuser  = upd_o_q;

	`BPVC_ASSERT_NEXT(a_pop_starts_mul, q_pop, state_q == ST_MUL)
	`BPVC_ASSERT_NEXT(a_commit_shows_beat, commit, m_valid_q)
	`BPVC_ASSERT(a_integral_range, (integral_q <= LIM_POS) && (integral_q >= LIM_NEG))
	`BPVC_ASSERT_NEXT(a_start_arms_pwm, commit && (item_q.op == OP_START), pwm_q && (duty_q == '0))
endmodule

// File: rtl/core/buck_pi_voltage_controller_unit.sv
`timescale 1ns / 1ps
// Buck converter voltage PI controller with soft start and current trip.
// Input beats (s_axis): tuser = cmd (tick, current sample, start), tdata =
// voltage and current ADC samples. Every input beat yields exactly one
// output beat (m_axis) with the held duty, a duty_updated flag in tuser,
// the PWM enable and the present reference.
// Config (cfg_*): register index and data, taken on any cycle; write only
// while no beat is in flight.
// The back end takes each beat through error, P and integral with their
// multiply, I multiply, sum and commit, and pops no new beat until it has
// committed the last one; the front end classifies each beat in its accept
// cycle and keeps the sample and soft start counters.
// A four-entry queue sits between front and back. A stalled m_axis holds
// its beat in the output register; the back end waits at commit, the queue
// fills and s_axis_tready then drops.
// Reset loads the default config, clears counters, integral and duty,
// sets the reference to the start default and leaves PWM off.
module buck_pi_voltage_controller_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [9:0] voltage_sample, [19:10] current_sample, rest zero
	input  logic [bpvc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// [1:0] cmd
	input  logic [1:0]                       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [11:0] duty, [12] pwm_enable, [29:13] reference_now, rest zero
	output logic [bpvc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// [0] duty_updated
	output logic [0:0]                       m_axis_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bpvc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bpvc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bpvc_pkg::*;

	cfg_t     cfg_q;
	logic     push;
	fe_item_t push_item;
	logic     q_full;
	logic     q_pop;
	logic     q_valid;
	fe_item_t q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.p_gain      <= RST_P_GAIN;
			cfg_q.i_gain      <= RST_I_GAIN;
			cfg_q.target_ref  <= RST_TARGET;
			cfg_q.start_ref   <= RST_START_REF;
			cfg_q.pid_period  <= RST_PID_PER;
			cfg_q.soft_period <= RST_SOFT_PER;
			cfg_q.cur_limit   <= RST_CUR_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_P_GAIN:    cfg_q.p_gain      <= cfg_data[GAIN_W-1:0];
				REG_I_GAIN:    cfg_q.i_gain      <= cfg_data[GAIN_W-1:0];
				REG_TARGET:    cfg_q.target_ref  <= cfg_data[TGT_W-1:0];
				REG_START_REF: cfg_q.start_ref   <= $signed(cfg_data[REF_W-1:0]);
				REG_PID_PER:   cfg_q.pid_period  <= cfg_data[PID_W-1:0];
				REG_SOFT_PER:  cfg_q.soft_period <= cfg_data[SOFT_W-1:0];
				REG_CUR_LIMIT: cfg_q.cur_limit   <= cfg_data[ADC_W-1:0];
				default: ;
			endcase
		end
	end

	bpvc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.push          (push),
		.push_item     (push_item)
	);

	bpvc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.q_valid   (q_valid),
		.head      (q_head)
	);

	bpvc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);
endmodule

// File: tb/sv/buck_pi_voltage_controller_unit_checker.sv
`timescale 1ns / 1ps
module buck_pi_voltage_controller_unit_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	// [9:0] voltage_sample, [19:10] current_sample, rest zero
	input  logic [bpvc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// [1:0] cmd
	input  logic [1:0]                       s_axis_tuser,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [11:0] duty, [12] pwm_enable, [29:13] reference_now, rest zero
	input  logic [bpvc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// [0] duty_updated
	input  logic [0:0]                       m_axis_tuser,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [bpvc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bpvc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                               fail_count,
	output int                               pending
);
	import bpvc_pkg::*;

	typedef struct packed {
		logic signed [DUTY_W-1:0] duty;
		logic                     updated;
		logic                     pwm;
		logic signed [REF_W-1:0]  ref_now;
	} pi_result_t;

	// shadow config
	logic [GAIN_W-1:0]       kp;
	logic [GAIN_W-1:0]       ki;
	logic [TGT_W-1:0]        target;
	logic signed [REF_W-1:0] start_ref;
	logic [PID_W-1:0]        pid_per;
	logic [SOFT_W-1:0]       soft_per;
	logic [ADC_W-1:0]        cur_lim;

	// shadow loop state
	logic signed [PI_W-1:0]   integ;
	logic signed [REF_W-1:0]  vref;
	logic [ADC_W-1:0]         offs;
	logic [PID_W-1:0]         scnt;
	logic [SOFT_W-1:0]        rcnt;
	logic                     pwm;
	logic signed [DUTY_W-1:0] duty_q;

	pi_result_t want_q[$];

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		fail_count++;
	endtask

	function automatic longint clamp_pi(input longint v);
		if (v >= PI_LIMIT)
			return PI_LIMIT;
		if (v <= -PI_LIMIT)
			return -PI_LIMIT;
		return v;
	endfunction

	task automatic run_pi(input logic [ADC_W-1:0] vs);
		longint volt, err, p, acc, it, sum;
		volt = (longint'(vs) - (longint'(offs) + FB_BIAS)) * 2;
		if (volt < 0)
			volt = 0;
		err = longint'(vref) - volt;
		p = clamp_pi(err * longint'(kp));
		acc = clamp_pi(longint'(integ) + err);
		integ = acc[PI_W-1:0];
		it = clamp_pi(acc * longint'(ki));
		sum = clamp_pi(p + it);
		sum = sum >>> OUT_SHIFT;
		duty_q = sum[DUTY_W-1:0];
	endtask

	task automatic step_controller(input logic [1:0] cmd, input logic [ADC_W-1:0] vs,
			input logic [ADC_W-1:0] cs, output pi_result_t r);
		int  nxt;
		logic fired;
		fired = 1'b0;
		case (cmd)
			CMD_TICK: begin
				scnt = scnt + 1'b1;
				rcnt = rcnt + 1'b1;
				if (scnt >= pid_per) begin
					run_pi(vs);
					fired = 1'b1;
					scnt = '0;
				end
				if (rcnt >= soft_per) begin
					nxt = int'(vref) + 1;
					if (nxt >= int'(target))
						nxt = int'(target);
					vref = nxt[REF_W-1:0];
					rcnt = '0;
				end
			end
			CMD_CURR: begin
				if (cs >= cur_lim)
					pwm = 1'b0;
			end
			CMD_START: begin
				offs = vs;
				vref = start_ref;
				integ = '0;
				scnt = '0;
				rcnt = '0;
				duty_q = '0;
				pwm = 1'b1;
			end
			default: ;
		endcase
		r.duty = duty_q;
		r.updated = fired;
		r.pwm = pwm;
		r.ref_now = vref;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pi_result_t w, r;
		if (!arst_n) begin
			kp = RST_P_GAIN;
			ki = RST_I_GAIN;
			target = RST_TARGET;
			start_ref = RST_START_REF;
			pid_per = RST_PID_PER;
			soft_per = RST_SOFT_PER;
			cur_lim = RST_CUR_LIMIT;
			integ = '0;
			vref = RST_START_REF;
			offs = '0;
			scnt = '0;
			rcnt = '0;
			pwm = 1'b0;
			duty_q = '0;
			want_q.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (want_q.size() == 0) begin
					report_mismatch("output beat with no prediction pending");
				end else begin
					w = want_q.pop_front();
					if (m_axis_tdata[DUTY_W-1:0] !== w.duty)
						report_mismatch($sformatf("duty got %0d expected %0d",
							$signed(m_axis_tdata[DUTY_W-1:0]), w.duty));
					if (m_axis_tuser[0] !== w.updated)
						report_mismatch($sformatf("duty_updated got %b expected %b",
							m_axis_tuser[0], w.updated));
					if (m_axis_tdata[DUTY_W] !== w.pwm)
						report_mismatch($sformatf("pwm_enable got %b expected %b",
							m_axis_tdata[DUTY_W], w.pwm));
					if (m_axis_tdata[DUTY_W+REF_W:DUTY_W+1] !== w.ref_now)
						report_mismatch($sformatf("reference_now got %0d expected %0d",
							$signed(m_axis_tdata[DUTY_W+REF_W:DUTY_W+1]), w.ref_now));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				step_controller(s_axis_tuser, s_axis_tdata[ADC_W-1:0],
					s_axis_tdata[2*ADC_W-1:ADC_W], r);
				want_q.push_back(r);
			end
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_P_GAIN:    kp = cfg_data[GAIN_W-1:0];
					REG_I_GAIN:    ki = cfg_data[GAIN_W-1:0];
					REG_TARGET:    target = cfg_data[TGT_W-1:0];
					REG_START_REF: start_ref = cfg_data[REF_W-1:0];
					REG_PID_PER:   pid_per = cfg_data[PID_W-1:0];
					REG_SOFT_PER:  soft_per = cfg_data[SOFT_W-1:0];
					REG_CUR_LIMIT: cur_lim = cfg_data[ADC_W-1:0];
					default: ;
				endcase
			end
			pending <= want_q.size();
		end
	end

endmodule

// File: tb/sv/buck_pi_voltage_controller_unit_test.sv
`timescale 1ns / 1ps
module buck_pi_voltage_controller_unit_test;
	import bpvc_pkg::*;

	localparam logic [1:0]           CMD_UNUSED  = OP_HOLD;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 3'd7;
	localparam int                   STALL_LIMIT = 4000;
	localparam int                   RAND_PHASES = 9;
	localparam int                   PHASE_ITEMS = 200;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [1:0]             s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [0:0]             m_axis_tuser;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int fail_count;
	int pending;
	int quiet_cycles;
	bit calm;
	logic [ADC_W-1:0] lim_now;
	logic [ADC_W-1:0] offs_now;

	buck_pi_voltage_controller_unit dut (.*);

	buck_pi_voltage_controller_unit_checker checker_i (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= calm || ($urandom_range(99) >= 25);
	end

	// no beat on any channel for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("buck_pi_voltage_controller_unit_test failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic send_item(input logic [1:0] cmd, input logic [ADC_W-1:0] vs,
			input logic [ADC_W-1:0] cs);
		while (!calm && $urandom_range(99) < 25) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= IN_TDATA_W'({cs, vs});
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic write_config(input int p, input int i, input int t, input int s,
			input int pid, input int ramp_per, input int lim);
		cfg_write(REG_P_GAIN, p);
		cfg_write(REG_I_GAIN, i);
		cfg_write(REG_TARGET, t);
		cfg_write(REG_START_REF, s);
		cfg_write(REG_PID_PER, pid);
		cfg_write(REG_SOFT_PER, ramp_per);
		cfg_write(REG_CUR_LIMIT, lim);
		cfg_valid <= 1'b0;
		lim_now = lim[ADC_W-1:0];
	endtask

	task automatic random_config(input int ph);
		int p, i, t, s, pid, ramp_per, lim;
		p = $urandom_range(0, 64);
		i = $urandom_range(0, 16);
		t = $urandom_range(0, 2047);
		s = -int'($urandom_range(0, 2000));
		pid = $urandom_range(0, 12);
		ramp_per = $urandom_range(0, 24);
		lim = $urandom_range(512, 1023);
		case (ph)
			1: begin
				p = 1023;
				i = 0;
				s = -PI_LIMIT;
			end
			2: begin
				p = 0;
				i = 1023;
				pid = 127;
				ramp_per = 65535;
			end
			3: begin
				s = $urandom_range(0, 131071);
				lim = $urandom_range(0, 1023);
			end
			5: begin
				t = 0;
				s = -65536;
			end
			7: ramp_per = $urandom_range(100, 65535);
			8: lim = 0;
			default: ;
		endcase
		write_config(p, i, t, s, pid, ramp_per, lim);
	endtask

	initial begin
		int ph, k, roll;
		logic [ADC_W-1:0] vs, cs;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= CMD_TICK;
		cfg_valid <= 1'b0;
		cfg_index <= REG_P_GAIN;
		cfg_data <= '0;
		calm = 1'b0;
		lim_now = RST_CUR_LIMIT;
		offs_now = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, nothing started yet
		send_item(CMD_UNUSED, 10'h3ff, 10'h3ff);
		send_item(CMD_CURR, 10'h000, 10'h3ff);
		repeat (10) send_item(CMD_TICK, ADC_W'($urandom_range(1023)), 10'h000);
		wait_drained();

		// top extremes, zero periods, zero trip level
		cfg_write(REG_SPARE, 131071);
		write_config(1023, 1023, 2047, -PI_LIMIT, 0, 0, 0);
		send_item(CMD_START, 10'h3ff, 10'h000);
		send_item(CMD_TICK, 10'h000, 10'h3ff);
		send_item(CMD_TICK, 10'h3ff, 10'h000);
		send_item(CMD_CURR, 10'h3ff, 10'h000);
		send_item(CMD_TICK, 10'h200, 10'h200);
		send_item(CMD_START, 10'h000, 10'h3ff);
		send_item(CMD_TICK, 10'h3ff, 10'h3ff);
		send_item(CMD_UNUSED, 10'h000, 10'h000);
		wait_drained();

		// zero gains, start reference above target
		write_config(0, 0, 0, 65535, 1, 1, 1023);
		send_item(CMD_START, 10'h000, 10'h000);
		send_item(CMD_TICK, 10'h3ff, 10'h000);
		send_item(CMD_TICK, 10'h000, 10'h155);
		send_item(CMD_CURR, 10'h2aa, 10'h3fe);
		send_item(CMD_CURR, 10'h155, 10'h3ff);
		send_item(CMD_TICK, 10'h2aa, 10'h2aa);

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			wait_drained();
			random_config(ph);
			calm <= (ph == 4);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == 6 && k == PHASE_ITEMS / 2)
					wait_drained();
				roll = $urandom_range(99);
				if (k == 0 || roll < 3) begin
					offs_now = ($urandom_range(3) == 0) ? ADC_W'($urandom_range(1023)) :
						ADC_W'($urandom_range(0, 200));
					send_item(CMD_START, offs_now, ADC_W'($urandom_range(1023)));
				end else if (roll < 5) begin
					send_item(CMD_UNUSED, ADC_W'($urandom_range(1023)),
						ADC_W'($urandom_range(1023)));
				end else if (roll < 17) begin
					if (lim_now > 0 && $urandom_range(9) < 8)
						cs = ADC_W'($urandom_range(0, lim_now - 1));
					else
						cs = ADC_W'($urandom_range(1023));
					send_item(CMD_CURR, ADC_W'($urandom_range(1023)), cs);
				end else begin
					if ($urandom_range(3) == 0)
						vs = ADC_W'($urandom_range(1023));
					else
						vs = offs_now + ADC_W'($urandom_range(0, 600));
					send_item(CMD_TICK, vs, ADC_W'($urandom_range(1023)));
				end
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("buck_pi_voltage_controller_unit_test passed");
		else
			$display("buck_pi_voltage_controller_unit_test failed");
		$finish;
	end

endmodule
